FILE: design/trd_pkg.sv
// shared types, constants and byte classes for the utf-16 / gb2312 text run detector
package trd_pkg;

  localparam int LEN_BITS = 16;
  localparam int CFG_BITS = 16;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [LEN_BITS:0]   len_sum_t;
  typedef logic [CFG_BITS-1:0] cfg_data_t;

  typedef enum logic [0:0] {
    REG_SCAN_LIMIT = 1'b0,
    REG_UTF16_MIN  = 1'b1
  } reg_idx_t;

  localparam len_t      LEN_MAX            = {LEN_BITS{1'b1}};
  localparam cfg_data_t SCAN_LIMIT_RESET   = 16'd4096;
  localparam cfg_data_t UTF16_MIN_RESET    = 16'd10;

  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd127;
  localparam logic [7:0] GB_LEAD_LO = 8'ha1;
  localparam logic [7:0] GB_LEAD_HI = 8'hf7;
  localparam logic [7:0] GB_TRAIL_LO = 8'ha1;
  localparam logic [7:0] GB_TRAIL_HI = 8'hfe;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CH_NUL) || (b == CH_CR) || (b == CH_LF) || (b == CH_TAB);
  endfunction

  function automatic len_t sat_len(input len_sum_t s);
    return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
  endfunction

endpackage

FILE: design/text_run_detector_utf16_gb2312.sv
// top level of the utf-16le / gb2312 text run detector
//
// a buffer streams in one word (one byte) per cycle while in_ready is high
// on the in_ channel, with in_last_byte set on its final word. one result per
// buffer leaves on the out_ channel: is_text, is_utf16 and the run length in
// bytes (saturating). words without the last flag give no result.
// an input register holds the accepted word; as that word leaves it, both scans
// update their state from it and, on the last word, load the result register.
// throughput is one word per cycle; the result register is the only stage
// that can hold, and non-last words keep flowing while it waits.
// when the receiver stalls, a last word waits in the input register and
// in_ready drops until the pending result is taken.
// each cfg_ write sets scan_limit or utf16_min_bytes, chosen by cfg_index;
// write them only while no buffer is in flight.
// reset (rst_n low, synchronous) empties both registers, clears the scan
// state and loads scan_limit 4096 and utf16_min_bytes 10. scan state also
// returns to its reset values after each last word.
module text_run_detector_utf16_gb2312 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_is_text,
  output logic                out_is_utf16,
  output trd_pkg::len_t       out_text_length,
  input  logic                cfg_write_en,
  input  trd_pkg::reg_idx_t   cfg_index,
  input  trd_pkg::cfg_data_t  cfg_wdata
);
  import trd_pkg::*;

  cfg_data_t scan_limit_r;
  cfg_data_t utf16_min_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       adv;

  logic       par_r, par_nxt;
  len_t       wide_len_r, wide_len_nxt;
  logic       wide_alive_r, wide_alive_nxt;
  logic [7:0] wide_low_r, wide_low_nxt;
  len_t       mb_pos_r, mb_pos_nxt;
  logic       mb_done_r, mb_done_nxt;
  logic       mb_found_r, mb_found_nxt;
  logic [7:0] mb_lead_r, mb_lead_nxt;
  logic       mb_lead_valid_r, mb_lead_valid_nxt;

  len_t       w_wide_len;
  logic       w_wide_alive;
  logic [7:0] w_wide_low;
  len_t       w_mb_pos;
  logic       w_mb_done;
  logic       w_mb_found;
  logic [7:0] w_mb_lead;
  logic       w_mb_lead_valid;

  logic       pair_ok;
  logic       take_single;
  logic [7:0] single_byte;
  len_sum_t   np_one;
  len_sum_t   np_two;
  len_sum_t   wide_sum;

  logic       out_valid_r, out_valid_nxt;
  logic       out_is_text_r, out_is_text_nxt;
  logic       out_is_utf16_r, out_is_utf16_nxt;
  len_t       out_len_r, out_len_nxt;

  // handshake
  assign adv      = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  assign out_valid       = out_valid_r;
  assign out_is_text     = out_is_text_r;
  assign out_is_utf16    = out_is_utf16_r;
  assign out_text_length = out_len_r;

  always_comb begin
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RESET;
      utf16_min_r  <= UTF16_MIN_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_SCAN_LIMIT: scan_limit_r <= cfg_wdata;
        REG_UTF16_MIN:  utf16_min_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // scan update for the word in the input register
  assign np_one   = {1'b0, mb_pos_r} + len_sum_t'(1);
  assign np_two   = {1'b0, mb_pos_r} + len_sum_t'(2);
  assign wide_sum = {1'b0, wide_len_r} + len_sum_t'(2);

  always_comb begin
    w_wide_len      = wide_len_r;
    w_wide_alive    = wide_alive_r;
    w_wide_low      = wide_low_r;
    w_mb_pos        = mb_pos_r;
    w_mb_done       = mb_done_r;
    w_mb_found      = mb_found_r;
    w_mb_lead       = mb_lead_r;
    w_mb_lead_valid = mb_lead_valid_r;
    pair_ok         = 1'b0;
    take_single     = 1'b0;
    single_byte     = s1_byte_r;

    // utf-16le pairs
    if (!par_r) begin
      w_wide_low = s1_byte_r;
    end else if (wide_alive_r) begin
      if (s1_byte_r == CH_NUL && is_printable(wide_low_r)) begin
        w_wide_len = sat_len(wide_sum);
      end else begin
        w_wide_alive = 1'b0;
      end
    end

    // gb2312 / ascii scan
    if (!mb_done_r) begin
      if (mb_lead_valid_r) begin
        w_mb_lead_valid = 1'b0;
        if (s1_byte_r inside {[GB_TRAIL_LO:GB_TRAIL_HI]}) begin
          pair_ok = 1'b1;
        end else begin
          take_single = 1'b1;
          single_byte = mb_lead_r;
        end
      end else if ((s1_byte_r inside {[GB_LEAD_LO:GB_LEAD_HI]}) && !s1_last_r) begin
        w_mb_lead       = s1_byte_r;
        w_mb_lead_valid = 1'b1;
      end else begin
        take_single = 1'b1;
      end
    end

    if (pair_ok) begin
      w_mb_pos = sat_len(np_two);
      if (np_two > {1'b0, scan_limit_r} && !s1_last_r) begin
        w_mb_done = 1'b1;
      end
    end else if (take_single) begin
      if (is_printable(single_byte)) begin
        w_mb_pos = sat_len(np_one);
        if (np_one > {1'b0, scan_limit_r} && !s1_last_r) begin
          w_mb_done = 1'b1;
        end
      end else if (mb_pos_r != '0 && is_terminator(single_byte)) begin
        w_mb_pos   = sat_len(np_one);
        w_mb_found = 1'b1;
        w_mb_done  = 1'b1;
      end else begin
        w_mb_pos  = '0;
        w_mb_done = 1'b1;
      end
    end
  end

  // next state: hold, advance, or clear after the last word
  always_comb begin
    par_nxt           = par_r;
    wide_len_nxt      = wide_len_r;
    wide_alive_nxt    = wide_alive_r;
    wide_low_nxt      = wide_low_r;
    mb_pos_nxt        = mb_pos_r;
    mb_done_nxt       = mb_done_r;
    mb_found_nxt      = mb_found_r;
    mb_lead_nxt       = mb_lead_r;
    mb_lead_valid_nxt = mb_lead_valid_r;
    if (adv) begin
      if (s1_last_r) begin
        par_nxt           = 1'b0;
        wide_len_nxt      = '0;
        wide_alive_nxt    = 1'b1;
        wide_low_nxt      = '0;
        mb_pos_nxt        = '0;
        mb_done_nxt       = 1'b0;
        mb_found_nxt      = 1'b0;
        mb_lead_nxt       = '0;
        mb_lead_valid_nxt = 1'b0;
      end else begin
        par_nxt           = ~par_r;
        wide_len_nxt      = w_wide_len;
        wide_alive_nxt    = w_wide_alive;
        wide_low_nxt      = w_wide_low;
        mb_pos_nxt        = w_mb_pos;
        mb_done_nxt       = w_mb_done;
        mb_found_nxt      = w_mb_found;
        mb_lead_nxt       = w_mb_lead;
        mb_lead_valid_nxt = w_mb_lead_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r           <= 1'b0;
      wide_len_r      <= '0;
      wide_alive_r    <= 1'b1;
      wide_low_r      <= '0;
      mb_pos_r        <= '0;
      mb_done_r       <= 1'b0;
      mb_found_r      <= 1'b0;
      mb_lead_r       <= '0;
      mb_lead_valid_r <= 1'b0;
    end else begin
      par_r           <= par_nxt;
      wide_len_r      <= wide_len_nxt;
      wide_alive_r    <= wide_alive_nxt;
      wide_low_r      <= wide_low_nxt;
      mb_pos_r        <= mb_pos_nxt;
      mb_done_r       <= mb_done_nxt;
      mb_found_r      <= mb_found_nxt;
      mb_lead_r       <= mb_lead_nxt;
      mb_lead_valid_r <= mb_lead_valid_nxt;
    end
  end

  // result register
  always_comb begin
    out_is_text_nxt  = out_is_text_r;
    out_is_utf16_nxt = out_is_utf16_r;
    out_len_nxt      = out_len_r;
    if (w_wide_len > utf16_min_r) begin
      out_is_text_nxt  = 1'b1;
      out_is_utf16_nxt = 1'b1;
      out_len_nxt      = w_wide_len;
    end else begin
      out_is_text_nxt  = w_mb_found || !w_mb_done;
      out_is_utf16_nxt = 1'b0;
      out_len_nxt      = w_mb_pos;
    end
  end

  always_comb begin
    if (adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_is_text_r  <= out_is_text_nxt;
      out_is_utf16_r <= out_is_utf16_nxt;
      out_len_r      <= out_len_nxt;
    end
  end

  // checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> (!par_r && wide_alive_r && wide_len_r == '0 &&
                            mb_pos_r == '0 && !mb_done_r && !mb_lead_valid_r))
    else $error("scan state not cleared after last word");

  a_utf16_is_text: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_is_utf16_r) |-> out_is_text_r)
    else $error("utf-16 result not flagged as text");

  a_wide_even: assert property (@(posedge clk) disable iff (!rst_n)
    (!wide_len_r[0] || wide_len_r == LEN_MAX))
    else $error("wide run length odd before saturation");

  a_lead_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    mb_lead_valid_r |-> !mb_done_r)
    else $error("gb2312 lead held after scan finished");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(adv && s1_last_r))
    else $error("result without a last word");

endmodule

FILE: verif/tb_text_run_detector_utf16_gb2312.sv
`timescale 1ns / 100ps
// self-checking testbench for the utf-16le / gb2312 text run detector
module tb_text_run_detector_utf16_gb2312;
  import trd_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int WORD_TARGET = 700;

  typedef struct packed {
    logic is_text;
    logic is_utf16;
    len_t length;
  } run_verdict_t;

  class text_run_scoreboard;
    run_verdict_t verdict_q[$];
    int mismatch_count;
    cfg_data_t cfg_scan_limit;
    cfg_data_t cfg_utf16_min;
    logic odd_phase;
    len_t wide_len;
    logic wide_alive;
    logic [7:0] wide_low;
    len_t mb_pos;
    logic mb_done;
    logic mb_found;
    logic [7:0] mb_lead;
    logic mb_lead_ok;

    function new();
      cfg_scan_limit = SCAN_LIMIT_RESET;
      cfg_utf16_min = UTF16_MIN_RESET;
      mismatch_count = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      odd_phase = 1'b0;
      wide_len = '0;
      wide_alive = 1'b1;
      wide_low = '0;
      mb_pos = '0;
      mb_done = 1'b0;
      mb_found = 1'b0;
      mb_lead = '0;
      mb_lead_ok = 1'b0;
    endfunction

    function void set_reg(reg_idx_t idx, cfg_data_t value);
      case (idx)
        REG_SCAN_LIMIT: cfg_scan_limit = value;
        REG_UTF16_MIN: cfg_utf16_min = value;
        default: ;
      endcase
    endfunction

    function logic plain_byte(logic [7:0] b);
      return (b >= PRINT_LO) && (b <= PRINT_HI);
    endfunction

    function logic run_end_byte(logic [7:0] b);
      return (b == CH_NUL) || (b == CH_CR) || (b == CH_LF) || (b == CH_TAB);
    endfunction

    // advance the multibyte position, the limit stops only a non-final step
    function void mb_advance(int k, logic last);
      int np;
      np = int'(mb_pos) + k;
      if (np > int'(cfg_scan_limit) && !last) mb_done = 1'b1;
      mb_pos = (np > int'(LEN_MAX)) ? LEN_MAX : len_t'(np);
    endfunction

    function void mb_lone(logic [7:0] b, logic last);
      if (plain_byte(b)) begin
        mb_advance(1, last);
      end else begin
        if (mb_pos != 0 && run_end_byte(b)) begin
          mb_advance(1, 1'b1);
          mb_found = 1'b1;
        end else begin
          mb_pos = '0;
        end
        mb_done = 1'b1;
      end
    endfunction

    function void take_word(logic [7:0] b, logic last);
      run_verdict_t v;
      if (!odd_phase) begin
        wide_low = b;
      end else if (wide_alive) begin
        if (b == 8'h00 && plain_byte(wide_low)) begin
          wide_len = (wide_len >= LEN_MAX - 1) ? LEN_MAX : wide_len + len_t'(2);
        end else begin
          wide_alive = 1'b0;
        end
      end
      odd_phase = !odd_phase;

      if (!mb_done) begin
        if (mb_lead_ok) begin
          mb_lead_ok = 1'b0;
          if (b >= GB_TRAIL_LO && b <= GB_TRAIL_HI) mb_advance(2, last);
          else mb_lone(mb_lead, last);
        end else if (b >= GB_LEAD_LO && b <= GB_LEAD_HI && !last) begin
          mb_lead = b;
          mb_lead_ok = 1'b1;
        end else begin
          mb_lone(b, last);
        end
      end

      if (last) begin
        if (wide_len > cfg_utf16_min) begin
          v.is_text = 1'b1;
          v.is_utf16 = 1'b1;
          v.length = wide_len;
        end else begin
          v.is_text = mb_found || !mb_done;
          v.is_utf16 = 1'b0;
          v.length = mb_pos;
        end
        verdict_q.push_back(v);
        clear_scan();
      end
    endfunction

    function void check_word(logic is_text, logic is_utf16, len_t length);
      run_verdict_t e;
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: text=%0b utf16=%0b len=%0d", is_text, is_utf16, length);
        return;
      end
      e = verdict_q.pop_front();
      if (e.is_text !== is_text || e.is_utf16 !== is_utf16 || e.length !== length) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result differs: expected text=%0b utf16=%0b len=%0d, got text=%0b utf16=%0b len=%0d",
                   e.is_text, e.is_utf16, e.length, is_text, is_utf16, length);
      end
    endfunction

    function int pending_count();
      return verdict_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_data_byte;
  logic in_last_byte;
  logic out_valid;
  logic out_ready;
  logic out_is_text;
  logic out_is_utf16;
  len_t out_text_length;
  logic cfg_write_en;
  reg_idx_t cfg_index;
  cfg_data_t cfg_wdata;

  text_run_scoreboard sb = new();
  logic [7:0] frame_q[$];
  logic calm;
  int words_sent;
  int cycle_count;

  text_run_detector_utf16_gb2312 i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_is_text(out_is_text),
    .out_is_utf16(out_is_utf16),
    .out_text_length(out_text_length),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [7:0] pick_run_end();
    case ($urandom_range(0, 3))
      0: return CH_NUL;
      1: return CH_CR;
      2: return CH_LF;
      default: return CH_TAB;
    endcase
  endfunction

  task automatic send_frame();
    int gap;
    foreach (frame_q[i]) begin
      gap = pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= frame_q[i];
      in_last_byte <= (i == frame_q.size() - 1);
      do @(posedge clk); while (!in_ready);
      sb.take_word(frame_q[i], i == frame_q.size() - 1);
      words_sent++;
    end
  endtask

  task automatic apply_settings(input cfg_data_t limit, input cfg_data_t min_bytes);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_SCAN_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    sb.set_reg(REG_SCAN_LIMIT, limit);
    cfg_index <= REG_UTF16_MIN;
    cfg_wdata <= min_bytes;
    @(posedge clk);
    sb.set_reg(REG_UTF16_MIN, min_bytes);
    cfg_write_en <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver side
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_is_text, out_is_utf16, out_text_length);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int kind;
    cfg_data_t new_limit;
    cfg_data_t new_min;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_index <= REG_SCAN_LIMIT;
    cfg_wdata <= '0;
    calm = 1'b0;
    words_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed buffers, short wide runs count as text here
    apply_settings(SCAN_LIMIT_RESET, 16'd2);
    frame_q = '{8'h41, CH_NUL, 8'h42, CH_NUL};
    send_frame();
    // odd trailing byte
    frame_q = '{8'h41, CH_NUL, 8'h42, CH_NUL, 8'h43};
    send_frame();
    frame_q = '{8'hb0, 8'ha1, CH_CR};
    send_frame();
    // lead byte as final byte
    frame_q = '{GB_LEAD_HI};
    send_frame();
    frame_q = '{GB_LEAD_LO, GB_TRAIL_HI, PRINT_HI, CH_TAB};
    send_frame();
    frame_q = '{8'h41, 8'hff};
    send_frame();
    frame_q = '{CH_NUL};
    send_frame();
    frame_q = '{PRINT_LO, CH_LF, 8'h42};
    send_frame();
    // lead followed by a bad trail
    frame_q = '{8'hc0, 8'h41};
    send_frame();
    wait_idle();

    // limit of zero: stops unless reached on the final byte
    apply_settings(16'd0, 16'd2);
    frame_q = '{8'h41};
    send_frame();
    frame_q = '{8'h41, 8'h42};
    send_frame();
    wait_idle();
    frame_q.delete();

    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 5))
        0: new_limit = 16'd0;
        1: new_limit = 16'hffff;
        2: new_limit = SCAN_LIMIT_RESET;
        default: new_limit = cfg_data_t'($urandom_range(0, 24));
      endcase
      case ($urandom_range(0, 4))
        0: new_min = 16'd0;
        1: new_min = 16'hffff;
        2: new_min = UTF16_MIN_RESET;
        default: new_min = cfg_data_t'($urandom_range(0, 20));
      endcase
      apply_settings(new_limit, new_min);
      calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(4, 12)) begin
        frame_q.delete();
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          // wide run with an optional random tail
          repeat ($urandom_range(0, 12)) begin
            frame_q.push_back(8'($urandom_range(32, 127)));
            frame_q.push_back(CH_NUL);
          end
          case ($urandom_range(0, 3))
            1: frame_q.push_back(8'($urandom));
            2: begin
              frame_q.push_back(8'($urandom_range(32, 127)));
              frame_q.push_back(8'($urandom_range(1, 255)));
            end
            3: repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
            default: ;
          endcase
        end else if (kind < 7) begin
          // gb2312 pairs mixed with ascii
          repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(0, 1)) begin
              frame_q.push_back(8'($urandom_range(GB_LEAD_LO, GB_LEAD_HI)));
              frame_q.push_back(8'($urandom_range(GB_TRAIL_LO, GB_TRAIL_HI)));
            end else begin
              frame_q.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
            end
          end
          case ($urandom_range(0, 4))
            1: begin
              frame_q.push_back(pick_run_end());
              repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
            end
            2: frame_q.push_back(8'($urandom_range(GB_LEAD_LO, GB_LEAD_HI)));
            3: begin
              frame_q.push_back(8'($urandom_range(GB_LEAD_LO, GB_LEAD_HI)));
              if ($urandom_range(0, 1)) frame_q.push_back(8'hff);
              else frame_q.push_back(8'($urandom_range(0, GB_TRAIL_LO - 1)));
            end
            4: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
            default: ;
          endcase
        end else begin
          repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
        end
        if (frame_q.size() == 0) frame_q.push_back(pick_run_end());
        send_frame();
      end
      wait_idle();
    end

    if (sb.mismatch_count == 0 && sb.pending_count() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: sim.f
design/trd_pkg.sv
design/text_run_detector_utf16_gb2312.sv
verif/tb_text_run_detector_utf16_gb2312.sv
